// ===== rtl/rcs_pkg.sv =====
// Package: sizes, codes, state type and helpers of the repetition count stack.
package rcs_pkg;

    localparam int ENTRIES     = 128;
    localparam int STACK_DEPTH = 256;
    localparam int KEY_BITS    = 64;

    localparam int IN_KEY_W  = 64;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int STK_IDX_W = $clog2(STACK_DEPTH);
    localparam int TOP_W     = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W     = TOP_W;
    localparam int CNT_MAX   = 511;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_STACK_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_POP_EMPTY  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_PUSH_RD,
        S_PUSH_INC,
        S_PUSH_NEW,
        S_POP_IDX,
        S_POP_DEC,
        S_POP_TIDX,
        S_POP_TCNT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [KEY_BITS-1:0] key;
    } key_wr_t;

    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        if (32'(c) > 32'(CNT_MAX))
        begin
            return COUNT_W'(CNT_MAX);
        end
        return COUNT_W'(c);
    endfunction

endpackage

// ===== rtl/rcs_if.sv =====
// Interfaces: request and response channels of the repetition count stack.
interface rcs_req_if;
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic [rcs_pkg::IN_KEY_W-1:0] key;

    modport source (output valid, output operation, output key, input ready);
    modport sink   (input valid, input operation, input key, output ready);
endinterface

interface rcs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rcs_pkg::COUNT_W-1:0]  repeat_count;
    logic [rcs_pkg::STATUS_W-1:0] status;

    modport source (output valid, output repeat_count, output status, input ready);
    modport sink   (input valid, input repeat_count, input status, output ready);
endinterface

// ===== rtl/rcs_key_table.sv =====
// Key table: key memory with one write port, registered read and equality compare.
module rcs_key_table (
    input  logic                         clk,
    input  logic [rcs_pkg::IDX_W-1:0]    raddr,
    input  rcs_pkg::key_wr_t             wr,
    input  logic [rcs_pkg::KEY_BITS-1:0] key_ref,
    output logic                         eq
);

    logic [rcs_pkg::KEY_BITS-1:0] key_mem [rcs_pkg::ENTRIES];
    logic [rcs_pkg::KEY_BITS-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr] <= wr.key;
        end
        rd_reg <= key_mem[raddr];
    end

    // compare the entry read last cycle against the searched key
    assign eq = (rd_reg == key_ref);

endmodule

// ===== rtl/repetition_count_stack_unit.sv =====
// Top level: stack of keys with a counted multiset of the distinct stacked keys.
//
// Each request beat is a push of a key or a pop of the top key; each yields exactly one
// response beat with the key's repeat count and a status (ok, stack full, table full,
// pop on empty). The block takes one request at a time and is not ready while it works.
// A push walks the key table one entry per cycle through a single comparator, stopping
// at the first used entry whose key matches; without a match it walks the whole table
// and then claims the first free entry or reports a full table. A pop reads the index
// stack and the count memory one after the other, then reads them again for the new top
// key unless the stack became empty. A push on a full stack or a pop on an empty one
// goes straight to the response. The response is held in an output register, so a
// stalled response only delays the next request's result, not its acceptance; a stall
// that lasts longer holds the block in its emit state and delays the request after that.
// Per-entry used bits reset at once; no clearing pass is needed.
module repetition_count_stack_unit (
    input  logic            clk,
    input  logic            rst_n,
    rcs_req_if.sink         req,
    rcs_rsp_if.source       rsp
);

    localparam int IDX_W     = rcs_pkg::IDX_W;
    localparam int STK_IDX_W = rcs_pkg::STK_IDX_W;
    localparam int TOP_W     = rcs_pkg::TOP_W;
    localparam int CNT_W     = rcs_pkg::CNT_W;
    localparam int KEY_BITS  = rcs_pkg::KEY_BITS;

    rcs_pkg::state_t state_reg, state_next;

    logic [TOP_W-1:0]           top_reg, top_next;
    logic [rcs_pkg::ENTRIES-1:0] used_reg, used_next;
    logic                       out_valid_reg, out_valid_next;
    logic [rcs_pkg::COUNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic [rcs_pkg::STATUS_W-1:0] out_st_reg, out_st_next;

    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                       free_found_reg, free_found_next;
    logic [IDX_W-1:0]           free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]           tgt_reg, tgt_next;
    logic [KEY_BITS-1:0]        key_ref_reg, key_ref_next;
    logic [rcs_pkg::COUNT_W-1:0]  res_cnt_reg, res_cnt_next;
    logic [rcs_pkg::STATUS_W-1:0] res_st_reg, res_st_next;

    // key table ports
    logic [IDX_W-1:0]  key_raddr;
    rcs_pkg::key_wr_t  key_wr;
    logic              key_eq;

    // count memory ports
    logic [CNT_W-1:0]  cnt_mem [rcs_pkg::ENTRIES];
    logic [IDX_W-1:0]  cnt_raddr;
    logic              cnt_we;
    logic [IDX_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [CNT_W-1:0]  cnt_rd_reg;

    // index stack ports
    logic [IDX_W-1:0]  stk_mem [rcs_pkg::STACK_DEPTH];
    logic [STK_IDX_W-1:0] stk_raddr;
    logic              stk_we;
    logic [IDX_W-1:0]  stk_rd_reg;

    logic              accept;
    logic              out_free;
    logic              top_full;
    logic              top_empty;
    logic              scan_last;
    logic              scan_hit;
    logic              scan_free_any;
    logic [TOP_W-1:0]  top_dec;

    assign accept        = req.valid && req.ready;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign top_full      = (top_reg == TOP_W'(rcs_pkg::STACK_DEPTH));
    assign top_empty     = (top_reg == '0);
    assign top_dec       = top_reg - TOP_W'(1);
    assign scan_last     = (cmp_idx_reg == IDX_W'(rcs_pkg::ENTRIES - 1));
    assign scan_hit      = used_reg[cmp_idx_reg] && key_eq;
    assign scan_free_any = free_found_reg || !used_reg[cmp_idx_reg];

    assign req.ready        = (state_reg == rcs_pkg::S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.repeat_count = out_cnt_reg;
    assign rsp.status       = out_st_reg;

    rcs_key_table u_key_table (
        .clk     (clk),
        .raddr   (key_raddr),
        .wr      (key_wr),
        .key_ref (key_ref_reg),
        .eq      (key_eq)
    );

    // count memory and index stack: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_raddr];
        if (stk_we)
        begin
            stk_mem[top_reg[STK_IDX_W-1:0]] <= tgt_reg;
        end
        stk_rd_reg <= stk_mem[stk_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == rcs_pkg::OP_PUSH)
                    begin
                        state_next = top_full ? rcs_pkg::S_EMIT : rcs_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = top_empty ? rcs_pkg::S_EMIT : rcs_pkg::S_POP_IDX;
                    end
                end
            end
            rcs_pkg::S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = rcs_pkg::S_PUSH_RD;
                end
                else if (scan_last)
                begin
                    state_next = scan_free_any ? rcs_pkg::S_PUSH_NEW : rcs_pkg::S_EMIT;
                end
            end
            rcs_pkg::S_PUSH_RD:  state_next = rcs_pkg::S_PUSH_INC;
            rcs_pkg::S_PUSH_INC: state_next = rcs_pkg::S_EMIT;
            rcs_pkg::S_PUSH_NEW: state_next = rcs_pkg::S_EMIT;
            rcs_pkg::S_POP_IDX:  state_next = rcs_pkg::S_POP_DEC;
            rcs_pkg::S_POP_DEC:
            begin
                state_next = top_empty ? rcs_pkg::S_EMIT : rcs_pkg::S_POP_TIDX;
            end
            rcs_pkg::S_POP_TIDX: state_next = rcs_pkg::S_POP_TCNT;
            rcs_pkg::S_POP_TCNT: state_next = rcs_pkg::S_EMIT;
            rcs_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rcs_pkg::S_IDLE;
                end
            end
            default: state_next = rcs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        top_next        = top_reg;
        used_next       = used_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        tgt_next        = tgt_reg;
        key_ref_next    = key_ref_reg;
        res_cnt_next    = res_cnt_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_cnt_next    = out_cnt_reg;
        out_st_next     = out_st_reg;

        key_raddr   = scan_idx_reg;
        key_wr.en   = 1'b0;
        key_wr.addr = tgt_reg;
        key_wr.key  = key_ref_reg;
        cnt_raddr   = tgt_reg;
        cnt_we      = 1'b0;
        cnt_waddr   = tgt_reg;
        cnt_wdata   = cnt_rd_reg;
        stk_raddr   = top_dec[STK_IDX_W-1:0];
        stk_we      = 1'b0;

        case (state_reg)
            rcs_pkg::S_IDLE:
            begin
                // prime the key table read with entry 0
                key_raddr = '0;
                if (accept)
                begin
                    key_ref_next    = req.key[KEY_BITS-1:0];
                    scan_idx_next   = IDX_W'(1);
                    cmp_idx_next    = '0;
                    free_found_next = 1'b0;
                    res_cnt_next    = '0;
                    if (req.operation == rcs_pkg::OP_PUSH)
                    begin
                        res_st_next = rcs_pkg::STAT_STACK_FULL;
                    end
                    else if (top_empty)
                    begin
                        res_st_next = rcs_pkg::STAT_POP_EMPTY;
                    end
                    else
                    begin
                        // the stack read at top-1 is already under way
                        top_next = top_dec;
                    end
                end
            end
            rcs_pkg::S_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                cmp_idx_next  = scan_idx_reg;
                if (!used_reg[cmp_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (scan_hit)
                begin
                    tgt_next = cmp_idx_reg;
                end
                else if (scan_last)
                begin
                    if (free_found_reg)
                    begin
                        tgt_next = free_idx_reg;
                    end
                    else if (!used_reg[cmp_idx_reg])
                    begin
                        tgt_next = cmp_idx_reg;
                    end
                    else
                    begin
                        res_cnt_next = '0;
                        res_st_next  = rcs_pkg::STAT_TABLE_FULL;
                    end
                end
            end
            rcs_pkg::S_PUSH_INC:
            begin
                cnt_we       = 1'b1;
                cnt_wdata    = cnt_rd_reg + CNT_W'(1);
                stk_we       = 1'b1;
                top_next     = top_reg + TOP_W'(1);
                res_cnt_next = rcs_pkg::sat_count(cnt_rd_reg + CNT_W'(1));
                res_st_next  = rcs_pkg::STAT_OK;
            end
            rcs_pkg::S_PUSH_NEW:
            begin
                key_wr.en          = 1'b1;
                cnt_we             = 1'b1;
                cnt_wdata          = CNT_W'(1);
                used_next[tgt_reg] = 1'b1;
                stk_we             = 1'b1;
                top_next           = top_reg + TOP_W'(1);
                res_cnt_next       = rcs_pkg::COUNT_W'(1);
                res_st_next        = rcs_pkg::STAT_OK;
            end
            rcs_pkg::S_POP_IDX:
            begin
                cnt_raddr = stk_rd_reg;
                tgt_next  = stk_rd_reg;
            end
            rcs_pkg::S_POP_DEC:
            begin
                cnt_we    = 1'b1;
                cnt_wdata = cnt_rd_reg - CNT_W'(1);
                if (cnt_rd_reg == CNT_W'(1))
                begin
                    used_next[tgt_reg] = 1'b0;
                end
                res_cnt_next = '0;
                res_st_next  = rcs_pkg::STAT_OK;
            end
            rcs_pkg::S_POP_TIDX:
            begin
                cnt_raddr = stk_rd_reg;
                tgt_next  = stk_rd_reg;
            end
            rcs_pkg::S_POP_TCNT:
            begin
                res_cnt_next = used_reg[tgt_reg] ? rcs_pkg::sat_count(cnt_rd_reg) : '0;
                res_st_next  = rcs_pkg::STAT_OK;
            end
            rcs_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = res_cnt_reg;
                    out_st_next    = res_st_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcs_pkg::S_IDLE;
            top_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        tgt_reg        <= tgt_next;
        key_ref_reg    <= key_ref_next;
        res_cnt_reg    <= res_cnt_next;
        res_st_reg     <= res_st_next;
        out_cnt_reg    <= out_cnt_next;
        out_st_reg     <= out_st_next;
    end

    // stack pointer never passes the depth
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TOP_W'(rcs_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");

    // a new key only claims a free entry
    a_new_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rcs_pkg::S_PUSH_NEW |-> !used_reg[tgt_reg])
        else $error("claimed entry already in use");

    // a pop only decrements a used entry
    a_pop_used: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rcs_pkg::S_POP_DEC |-> used_reg[tgt_reg])
        else $error("pop hit a free entry");

    // the last occurrence popped frees its entry
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rcs_pkg::S_POP_DEC && cnt_rd_reg == CNT_W'(1)
        |=> !used_reg[$past(tgt_reg)])
        else $error("entry not freed at zero count");

endmodule

// ===== dv/rcs_checker.sv =====
// Checker: predicts and compares the response beats of the repetition count stack.
module rcs_checker (
    input  logic clk,
    input  logic rst_n,
    rcs_req_if   req,
    rcs_rsp_if   rsp,
    output int   fail_count,
    output int   open_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rcs_pkg::COUNT_W-1:0]  repeat_count;
        logic [rcs_pkg::STATUS_W-1:0] status;
    } rsp_beat_t;

    logic [rcs_pkg::KEY_BITS-1:0] key_mem [rcs_pkg::ENTRIES];
    int unsigned         use_cnt [rcs_pkg::ENTRIES];
    int unsigned         idx_mem [rcs_pkg::STACK_DEPTH];
    int unsigned         depth;
    rsp_beat_t           pending_rsp_q [$];
    rsp_beat_t           want;
    int                  errs;
    int                  n;

    function automatic logic [rcs_pkg::COUNT_W-1:0] clip_count(input int unsigned c);
        return (c > rcs_pkg::CNT_MAX) ? rcs_pkg::COUNT_W'(rcs_pkg::CNT_MAX)
                                      : rcs_pkg::COUNT_W'(c);
    endfunction

    // Advance the shadow stack by one request and return the response it owes.
    function automatic rsp_beat_t apply_request(input logic op,
                                                input logic [rcs_pkg::IN_KEY_W-1:0] raw_key);
        logic [rcs_pkg::KEY_BITS-1:0] k;
        int                  hit;
        int                  free_slot;
        int                  i;
        rsp_beat_t           r;
        k = raw_key[rcs_pkg::KEY_BITS-1:0];
        r.repeat_count = '0;
        r.status = rcs_pkg::STAT_OK;
        if (op == rcs_pkg::OP_PUSH)
        begin
            if (depth >= rcs_pkg::STACK_DEPTH)
            begin
                r.status = rcs_pkg::STAT_STACK_FULL;
                return r;
            end
            hit = -1;
            free_slot = -1;
            for (i = 0; i < rcs_pkg::ENTRIES; i++)
            begin
                if (use_cnt[i] != 0)
                begin
                    if (hit < 0 && key_mem[i] == k)
                    begin
                        hit = i;
                    end
                end
                else if (free_slot < 0)
                begin
                    free_slot = i;
                end
            end
            if (hit < 0)
            begin
                if (free_slot < 0)
                begin
                    r.status = rcs_pkg::STAT_TABLE_FULL;
                    return r;
                end
                hit = free_slot;
                key_mem[hit] = k;
                use_cnt[hit] = 1;
            end
            else
            begin
                use_cnt[hit]++;
            end
            idx_mem[depth] = hit;
            depth++;
            r.repeat_count = clip_count(use_cnt[hit]);
            return r;
        end
        if (depth == 0)
        begin
            r.status = rcs_pkg::STAT_POP_EMPTY;
            return r;
        end
        depth--;
        i = idx_mem[depth];
        if (use_cnt[i] != 0)
        begin
            use_cnt[i]--;
        end
        if (depth != 0)
        begin
            r.repeat_count = clip_count(use_cnt[idx_mem[depth - 1]]);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (n = 0; n < rcs_pkg::ENTRIES; n++)
            begin
                use_cnt[n] = 0;
            end
            depth = 0;
            errs = 0;
            pending_rsp_q.delete();
            fail_count <= 0;
            open_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp_q.size() == 0)
                begin
                    if (errs < 10)
                    begin
                        $display("[%0t] unexpected response beat: count %0d status %0d",
                                 $realtime, rsp.repeat_count, rsp.status);
                    end
                    errs++;
                end
                else
                begin
                    want = pending_rsp_q.pop_front();
                    if (rsp.repeat_count !== want.repeat_count || rsp.status !== want.status)
                    begin
                        if (errs < 10)
                        begin
                            $display("[%0t] mismatch: count exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, want.repeat_count, rsp.repeat_count,
                                     want.status, rsp.status);
                        end
                        errs++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                pending_rsp_q.push_back(apply_request(req.operation, req.key));
            end
            fail_count <= errs;
            open_count <= pending_rsp_q.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: clock, reset, request stimulus, response stalls and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous guard: the slowest legal run stays far below this.
    localparam longint CYCLE_LIMIT = 1_000_000;
    // Drain time after the last response: one full table walk and some margin.
    localparam int     DRAIN_CYCLES = 140;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    int     fail_count;
    int     open_count;
    bit     quiet = 1'b0;
    longint cycles = 0;

    logic [rcs_pkg::IN_KEY_W-1:0] key_pool [8];
    logic [rcs_pkg::IN_KEY_W-1:0] fill_keys [$];

    rcs_req_if req_ch ();
    rcs_rsp_if rsp_ch ();

    repetition_count_stack_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rcs_checker count_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("repetition_count_stack_unit verification failed");
            $finish;
        end
    end

    // Response side: hold ready high for a random stretch, and now and then
    // drop it. The output register keeps the beat, so a stall lands on
    // whatever phase the block happens to be in. No stalls once quiet.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Present one request beat and hold it until the block takes it. Entry and
    // exit are at a rising edge; valid is only lowered when a gap follows, so
    // back-to-back beats keep valid high without a second assignment.
    task automatic send_beat(input logic op, input logic [rcs_pkg::IN_KEY_W-1:0] k);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.key       <= k;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Pop with a random key: the key must not matter on a pop.
    task automatic pop_beat();
        send_beat(rcs_pkg::OP_POP, {$urandom, $urandom});
    endtask

    // Mixed traffic over a small key pool: mostly repeats of pooled keys, some
    // single-bit neighbors of them (near misses for the comparator) and some
    // fresh keys that refresh the pool. The push share varies per round, so
    // the stack drifts up or down.
    task automatic run_mixed(input int n);
        int                  push_pct;
        int                  pick;
        int                  i;
        logic [rcs_pkg::IN_KEY_W-1:0] k;
        push_pct = $urandom_range(40, 70);
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(1, 100) <= push_pct)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    k = key_pool[$urandom_range(0, 7)];
                end
                else if (pick < 8)
                begin
                    k = key_pool[$urandom_range(0, 7)] ^ (64'd1 << $urandom_range(0, 63));
                end
                else
                begin
                    k = {$urandom, $urandom};
                    key_pool[$urandom_range(0, 7)] = k;
                end
                send_beat(rcs_pkg::OP_PUSH, k);
            end
            else
            begin
                pop_beat();
            end
        end
    endtask

    initial
    begin
        logic [rcs_pkg::IN_KEY_W-1:0] k;
        int                  i;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= rcs_pkg::OP_PUSH;
        req_ch.key       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: pop on empty, key extremes, repeated keys, single-bit
        // differences, then unwind to empty and pop on empty once more.
        pop_beat();
        send_beat(rcs_pkg::OP_PUSH, 64'h0000_0000_0000_0000);
        send_beat(rcs_pkg::OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(rcs_pkg::OP_PUSH, 64'h0000_0000_0000_0000);
        send_beat(rcs_pkg::OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_beat(rcs_pkg::OP_PUSH, 64'h8000_0000_0000_0000);
        send_beat(rcs_pkg::OP_PUSH, 64'h0000_0000_0000_0000);
        send_beat(rcs_pkg::OP_PUSH, 64'h5555_5555_5555_5555);
        send_beat(rcs_pkg::OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        for (i = 0; i < 9; i++)
        begin
            pop_beat();
        end

        // Stack full: push a handful of keys past the stack depth, so every
        // extra push is refused, then unwind past empty.
        for (i = 0; i < 3; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
        end
        for (i = 0; i < rcs_pkg::STACK_DEPTH + 6; i++)
        begin
            send_beat(rcs_pkg::OP_PUSH, key_pool[$urandom_range(0, 2)]);
        end
        for (i = 0; i < rcs_pkg::STACK_DEPTH + 9; i++)
        begin
            pop_beat();
        end

        // Table full: push more distinct keys than the table holds, then
        // re-push stored keys, which must still hit while the table is full.
        for (i = 0; i < rcs_pkg::ENTRIES + 6; i++)
        begin
            k = {$urandom, $urandom};
            if (i < rcs_pkg::ENTRIES)
            begin
                fill_keys.push_back(k);
            end
            send_beat(rcs_pkg::OP_PUSH, k);
        end
        for (i = 0; i < 8; i++)
        begin
            send_beat(rcs_pkg::OP_PUSH, fill_keys[$urandom_range(0, rcs_pkg::ENTRIES - 1)]);
        end
        for (i = 0; i < rcs_pkg::ENTRIES + 10; i++)
        begin
            pop_beat();
        end

        // Random mixed traffic; the last rounds run without any idling.
        for (i = 0; i < 8; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
        end
        for (i = 0; i < 8; i++)
        begin
            if (i == 6)
            begin
                quiet = 1'b1;
            end
            run_mixed(80);
        end

        req_ch.valid <= 1'b0;
        while (open_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && open_count == 0)
        begin
            $display("repetition_count_stack_unit verification clean");
        end
        else
        begin
            $display("repetition_count_stack_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rcs_pkg.sv
rtl/rcs_if.sv
rtl/rcs_key_table.sv
rtl/repetition_count_stack_unit.sv
dv/rcs_checker.sv
dv/tb_top.sv
